/* rtl/ppm_pkg.sv */
`timescale 1ns / 1ps
package ppm_pkg;

  localparam int CNT_W = 5;
  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] FULL_BYTE = 8'hFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic start;
    logic shift;
    logic setup;
    logic mul;
    logic dinit;
    logic dstep;
    logic compare;
    logic emit;
  } ppm_cmd_t;

  typedef struct packed {
    logic straddle;
  } ppm_stat_t;

endpackage

/* rtl/polygon_pixel_mask_core.sv */
`timescale 1ns / 1ps
// Even-odd point-in-polygon mask. A load request (cmd 0) writes one vertex
// into the table and gives no result. A test request (cmd 1) walks every
// edge of the polygon, closing edge included, one vertex per cycle from the
// vertex table except while a straddling edge is in the registered multiply
// and the restoring divider that yields one quotient bit per cycle, and gives
// one result: the inside flag and the pixel byte, with 255 forced to 0 when
// outside. One request is worked on at a time; a new request is taken while
// the previous result still waits in the output register. vertex_count must be
// written only while idle; the block itself does not enforce this. Values
// above MAX_VERTICES act as MAX_VERTICES, 0 always gives outside.
// Table entries read by a test must have been loaded since reset.
module polygon_pixel_mask_core import ppm_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 12,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [IDX_W-1:0]      in_vertex_index,
  input  logic [COORD_BITS-1:0] in_vertex_x,
  input  logic [COORD_BITS-1:0] in_vertex_y,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic [PIX_W-1:0]      in_pixel_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_inside_res,
  output logic [PIX_W-1:0]      out_pixel_out,
  input  logic                  cfg_wr_en,
  input  logic [CNT_W-1:0]      cfg_wr_data
);

  ppm_cmd_t         cmd;
  ppm_stat_t        stat;
  logic [IDX_W-1:0] rd_addr;

  ppm_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  ppm_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .stat            (stat),
    .in_vertex_index (in_vertex_index),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_pixel_value  (in_pixel_value),
    .out_inside_res  (out_inside_res),
    .out_pixel_out   (out_pixel_out)
  );

endmodule

/* rtl/ppm_datapath.sv */
`timescale 1ns / 1ps
module ppm_datapath import ppm_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 12,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic                  clk,
  input  ppm_cmd_t              cmd,
  input  logic [IDX_W-1:0]      rd_addr,
  output ppm_stat_t             stat,
  input  logic [IDX_W-1:0]      in_vertex_index,
  input  logic [COORD_BITS-1:0] in_vertex_x,
  input  logic [COORD_BITS-1:0] in_vertex_y,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic [PIX_W-1:0]      in_pixel_value,
  output logic                  out_inside_res,
  output logic [PIX_W-1:0]      out_pixel_out
);

  localparam int C   = COORD_BITS;
  localparam int P_W = 2 * (C + 1);

  logic [C-1:0] x_mem [MAX_VERTICES];
  logic [C-1:0] y_mem [MAX_VERTICES];

  logic [C-1:0]          rx_r, ry_r, px_r, py_r, tx_r, ty_r, xi_r;
  logic [PIX_W-1:0]      pix_r;
  logic                  inside_r;
  logic signed [C:0]     dx_r, dyt_r, den_r;
  logic signed [P_W-1:0] prod_r;
  logic                  neg_r;
  logic [C-1:0]          d_r, rem_r, quo_r;
  logic                  out_inside_res_r;
  logic [PIX_W-1:0]      out_pixel_out_r;

  logic                  wr_ok;
  logic [P_W-1:0]        mag_p;
  logic [C:0]            mag_d;
  logic [C:0]            trial, diff;
  logic                  ge;
  logic signed [C:0]     qs;
  logic signed [C+1:0]   cross_s, tx_s;
  logic                  lt;

  assign wr_ok = int'(in_vertex_index) < MAX_VERTICES;

  assign stat.straddle = (ry_r > ty_r) != (py_r > ty_r);

  assign mag_p = prod_r[P_W-1] ? P_W'(-prod_r) : P_W'(prod_r);
  assign mag_d = den_r[C] ? (C+1)'(-den_r) : (C+1)'(den_r);

  // one quotient bit per step, quotient magnitude fits the coordinate width
  assign trial = {rem_r, quo_r[C-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  assign qs      = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign cross_s = {qs[C], qs} + $signed({2'b00, xi_r});
  assign tx_s    = $signed({2'b00, tx_r});
  assign lt      = tx_s < cross_s;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      x_mem[in_vertex_index] <= in_vertex_x;
      y_mem[in_vertex_index] <= in_vertex_y;
    end
    rx_r <= x_mem[rd_addr];
    ry_r <= y_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tx_r     <= in_pixel_x;
      ty_r     <= in_pixel_y;
      pix_r    <= in_pixel_value;
      inside_r <= 1'b0;
    end else if (cmd.compare) begin
      inside_r <= inside_r ^ lt;
    end
    if (cmd.shift) begin
      px_r <= rx_r;
      py_r <= ry_r;
    end
    if (cmd.setup) begin
      dx_r  <= $signed({1'b0, px_r}) - $signed({1'b0, rx_r});
      dyt_r <= $signed({1'b0, ty_r}) - $signed({1'b0, ry_r});
      den_r <= $signed({1'b0, py_r}) - $signed({1'b0, ry_r});
      xi_r  <= rx_r;
    end
    if (cmd.mul) begin
      prod_r <= dx_r * dyt_r;
    end
    if (cmd.dinit) begin
      neg_r <= prod_r[P_W-1] ^ den_r[C];
      rem_r <= mag_p[2*C-1:C];
      quo_r <= mag_p[C-1:0];
      d_r   <= mag_d[C-1:0];
    end else if (cmd.dstep) begin
      rem_r <= ge ? diff[C-1:0] : trial[C-1:0];
      quo_r <= {quo_r[C-2:0], ge};
    end
    if (cmd.emit) begin
      out_inside_res_r <= inside_r;
      out_pixel_out_r  <= (!inside_r && pix_r == FULL_BYTE) ? '0 : pix_r;
    end
  end

  assign out_inside_res = out_inside_res_r;
  assign out_pixel_out  = out_pixel_out_r;

endmodule

/* rtl/ppm_ctrl.sv */
`timescale 1ns / 1ps
module ppm_ctrl import ppm_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 12,
  localparam int IDX_W = $clog2(MAX_VERTICES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  ppm_stat_t        stat,
  output ppm_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_addr
);

  localparam int STEP_W = $clog2(COORD_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COORD_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREV,
    S_EDGE,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_CMP,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  vertex_count_r, vertex_count_nxt;

  logic              in_acc;
  logic              sat;
  logic [IDX_W-1:0]  last_cfg;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sat      = int'(vertex_count_r) > MAX_VERTICES;
  assign last_cfg = sat ? IDX_W'(MAX_VERTICES - 1) : IDX_W'(vertex_count_r - CNT_W'(1));

  always_comb begin
    state_nxt        = state_r;
    i_nxt            = i_r;
    last_nxt         = last_r;
    step_nxt         = step_r;
    vertex_count_nxt = cfg_wr_en ? cfg_wr_data : vertex_count_r;
    cmd              = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.wr_en = 1'b1;
          end else if (in_cmd == CMD_TEST) begin
            cmd.start = 1'b1;
            last_nxt  = last_cfg;
            if (vertex_count_r == '0) begin
              state_nxt = S_FINISH;
            end else begin
              i_nxt     = last_cfg;
              state_nxt = S_PREV;
            end
          end
        end
      end
      S_PREV: begin
        cmd.shift = 1'b1;
        i_nxt     = '0;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (stat.straddle) begin
          cmd.setup = 1'b1;
          state_nxt = S_MUL;
        end else begin
          cmd.shift = 1'b1;
          if (i_r == last_r) begin
            state_nxt = S_FINISH;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_CMP;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        cmd.shift   = 1'b1;
        if (i_r == last_r) begin
          state_nxt = S_FINISH;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_EDGE;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.emit || (out_valid_r && out_stall);
  end

  // read address is the next walk index, so the registered read data matches the walk index
  assign rd_addr   = i_nxt;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      i_r            <= '0;
      last_r         <= '0;
      step_r         <= '0;
      out_valid_r    <= 1'b0;
      vertex_count_r <= CNT_W'(3);
    end else begin
      state_r        <= state_nxt;
      i_r            <= i_nxt;
      last_r         <= last_nxt;
      step_r         <= step_nxt;
      out_valid_r    <= out_valid_nxt;
      vertex_count_r <= vertex_count_nxt;
    end
  end

  a_start_flow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_PREV || state_r == S_FINISH))
    else $error("test request did not start a walk");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result overwrote a stalled request");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE || state_r == S_CMP) |-> (i_r <= last_r))
    else $error("edge index past last vertex");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r <= LAST_STEP))
    else $error("divider step count overran");

endmodule

/* test/polygon_pixel_mask_core_tb.sv */
`timescale 1ns / 1ps
module polygon_pixel_mask_core_tb import ppm_pkg::*; ();

  localparam int MAXV = 16;
  localparam int CW   = 12;
  localparam int IW   = 4;
  localparam int TOTAL_REQS = 1950;

  typedef struct packed {
    logic          cmd;
    logic [IW-1:0] vidx;
    logic [CW-1:0] vx;
    logic [CW-1:0] vy;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [PIX_W-1:0] pv;
  } pixel_req_t;

  typedef struct packed {
    logic             in_poly;
    logic [PIX_W-1:0] pix;
  } mask_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_cmd = CMD_LOAD;
  logic [IW-1:0]    in_vertex_index = '0;
  logic [CW-1:0]    in_vertex_x = '0;
  logic [CW-1:0]    in_vertex_y = '0;
  logic [CW-1:0]    in_pixel_x = '0;
  logic [CW-1:0]    in_pixel_y = '0;
  logic [PIX_W-1:0] in_pixel_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_inside_res;
  logic [PIX_W-1:0] out_pixel_out;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  pixel_req_t pending_reqs[$];
  mask_res_t  expected_masks[$];
  pixel_req_t cur_req;
  logic [CW-1:0]    corner_x[MAXV];
  logic [CW-1:0]    corner_y[MAXV];
  logic [CNT_W-1:0] poly_count = 5'd3;
  int err_count = 0;
  int pushed = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;

  polygon_pixel_mask_core #(
    .MAX_VERTICES(MAXV),
    .COORD_BITS  (CW)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_vertex_index(in_vertex_index),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res),
    .out_pixel_out  (out_pixel_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #25ms;
    $display("Regression FAIL");
    $finish;
  end

  // even-odd crossing test over the current polygon
  function automatic mask_res_t predict_mask(input logic [CW-1:0] tx, input logic [CW-1:0] ty,
                                             input logic [PIX_W-1:0] val);
    int n, i, j;
    longint lx, ly, xi, yi, xj, yj, xcross;
    logic hit;
    mask_res_t r;
    lx = tx;
    ly = ty;
    n = (poly_count > MAXV) ? MAXV : poly_count;
    hit = 1'b0;
    j = n - 1;
    for (i = 0; i < n; i++) begin
      xi = corner_x[i];
      yi = corner_y[i];
      xj = corner_x[j];
      yj = corner_y[j];
      if ((yi > ly) != (yj > ly)) begin
        xcross = (xj - xi) * (ly - yi) / (yj - yi) + xi;
        if (lx < xcross) hit = ~hit;
      end
      j = i;
    end
    r.in_poly = hit;
    r.pix = (!hit && val == FULL_BYTE) ? '0 : val;
    return r;
  endfunction

  // driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_req.cmd == CMD_LOAD) begin
          corner_x[cur_req.vidx] = cur_req.vx;
          corner_y[cur_req.vidx] = cur_req.vy;
        end else begin
          expected_masks.push_back(predict_mask(cur_req.px, cur_req.py, cur_req.pv));
        end
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid        <= 1'b1;
          in_cmd          <= cur_req.cmd;
          in_vertex_index <= cur_req.vidx;
          in_vertex_x     <= cur_req.vx;
          in_vertex_y     <= cur_req.vy;
          in_pixel_x      <= cur_req.px;
          in_pixel_y      <= cur_req.py;
          in_pixel_value  <= cur_req.pv;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result check and stall pattern
  always @(posedge clk) begin
    mask_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_masks.size() == 0) begin
        $error("unexpected result: inside_res %0d pixel_out %0d", out_inside_res, out_pixel_out);
        err_count++;
      end else begin
        want = expected_masks.pop_front();
        if (out_inside_res !== want.in_poly) begin
          $error("inside_res: expected %0d, actual %0d", want.in_poly, out_inside_res);
          err_count++;
        end
        if (out_pixel_out !== want.pix) begin
          $error("pixel_out: expected %0d, actual %0d", want.pix, out_pixel_out);
          err_count++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_cyc++;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ((stall_cyc % 64) < 40);
      end
    endcase
  end

  task automatic push_load(input int idx, input int x, input int y);
    pixel_req_t r;
    r.cmd  = CMD_LOAD;
    r.vidx = IW'(idx);
    r.vx   = CW'(x);
    r.vy   = CW'(y);
    r.px   = CW'($urandom_range(0, 4095));
    r.py   = CW'($urandom_range(0, 4095));
    r.pv   = PIX_W'($urandom_range(0, 255));
    pending_reqs.push_back(r);
    pushed++;
  endtask

  task automatic push_test(input int x, input int y, input int v);
    pixel_req_t r;
    r.cmd  = CMD_TEST;
    r.vidx = IW'($urandom_range(0, 15));
    r.vx   = CW'($urandom_range(0, 4095));
    r.vy   = CW'($urandom_range(0, 4095));
    r.px   = CW'(x);
    r.py   = CW'(y);
    r.pv   = PIX_W'(v);
    pending_reqs.push_back(r);
    pushed++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_masks.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    poly_count = v;
  endtask

  initial begin
    int specials[$];
    int phase, cnt, n_eff, n_load, n_tests, span, bx, by, x, y, prev_y, k, v;
    logic [CNT_W-1:0] next_count;
    specials = '{16, 3, 0, 1, 2, 31, 17, 16, 3, 8};
    for (k = 0; k < MAXV; k++) begin
      corner_x[k] = '0;
      corner_y[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // corners at the extremes of the coordinate range, rest random
    push_load(0, 0, 0);
    push_load(1, 4095, 0);
    push_load(2, 4095, 4095);
    push_load(3, 0, 4095);
    for (k = 4; k < MAXV; k++) push_load(k, $urandom_range(0, 4095), $urandom_range(0, 4095));
    push_test(4095, 4095, 255);
    push_test(0, 0, 255);
    push_test(3000, 1000, 255);
    push_test(1000, 3000, 255);
    push_test(2048, 2048, 17);
    drain();
    write_count(5'd4);
    push_test(0, 0, 255);
    push_test(2048, 2048, 255);
    push_test(4095, 2048, 255);
    push_test(0, 4095, 128);
    drain();

    phase = 0;
    while (pushed < TOTAL_REQS) begin
      if (phase < specials.size()) next_count = CNT_W'(specials[phase]);
      else if ($urandom_range(0, 9) == 0) next_count = CNT_W'($urandom_range(0, 31));
      else next_count = CNT_W'($urandom_range(3, 16));
      phase++;
      write_count(next_count);
      cnt = next_count;
      n_eff = (cnt > MAXV) ? MAXV : cnt;
      n_load = (n_eff < 3) ? 3 : n_eff;
      case ($urandom_range(0, 2))
        0: span = $urandom_range(8, 64);
        1: span = $urandom_range(65, 1024);
        default: span = 4095;
      endcase
      bx = $urandom_range(0, 4095 - span);
      by = $urandom_range(0, 4095 - span);
      prev_y = by;
      for (k = 0; k < n_load; k++) begin
        x = bx + $urandom_range(0, span);
        y = ($urandom_range(0, 4) == 0) ? prev_y : by + $urandom_range(0, span);
        prev_y = y;
        push_load(k, x, y);
      end
      n_tests = $urandom_range(10, 35);
      for (k = 0; k < n_tests; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          push_load($urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 4095));
        end
        v = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255);
        case ($urandom_range(0, 5))
          0: begin
            push_test($urandom_range(0, 4095), $urandom_range(0, 4095), v);
          end
          1: begin
            // pixel on a corner column and a corner row of the table as it stood before this batch
            push_test(corner_x[$urandom_range(0, n_load - 1)],
                      corner_y[$urandom_range(0, n_load - 1)], v);
          end
          default: begin
            x = bx + $urandom_range(0, span);
            y = by + $urandom_range(0, span);
            push_test(x, y, v);
          end
        endcase
      end
      drain();
    end

    drain();
    repeat (300) @(negedge clk);
    if (err_count == 0 && expected_masks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ppm_pkg.sv
rtl/ppm_datapath.sv
rtl/ppm_ctrl.sv
rtl/polygon_pixel_mask_core.sv
test/polygon_pixel_mask_core_tb.sv
